### rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants and types for the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;

  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = SLOT_W;
  localparam int NUM_W  = $clog2(FRAMES + 1);

  // Fixed port widths
  localparam int PAGE_PORT_W  = 16;
  localparam int FRAME_SLOT_W = 4;
  localparam int FAULT_W      = 32;
  localparam int CFG_W        = 5;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

  // Register index, taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  // Broadcast from the top level to every frame cell
  typedef struct packed {
    logic              clr;
    logic              upd;
    logic              hit;
    logic [RANK_W-1:0] hit_rank;
    logic [RANK_W-1:0] last_rank;
    logic [NUM_W-1:0]  active_n;
  } ctrl_t;

  // Per-cell lookup status
  typedef struct packed {
    logic match;
    logic first_empty;
    logic victim;
  } stat_t;

endpackage

### rtl/lru_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// Fully associative page frames with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Result: strobe done_o in the cycle after start is taken, unless a write
//   to frames_in_use comes in the same cycle. Throughput: one item per cycle;
//   busy stays low, as the frame cells compare, pick the slot and update ranks together.
// Reset: all frames empty, frames_in_use = 16, fault total zero. A write to
//   frames_in_use empties the frames and clears the total.
module lru_page_replacement_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [lpr_pkg::PAGE_PORT_W-1:0]   page_number_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic [lpr_pkg::FRAME_SLOT_W-1:0]  frame_slot_o,
  output logic                              evicted_valid_o,
  output logic [lpr_pkg::PAGE_PORT_W-1:0]   evicted_page_o,
  output logic [lpr_pkg::FAULT_W-1:0]       fault_total_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lpr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lpr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int F = lpr_pkg::FRAMES;

  logic [lpr_pkg::CFG_W-1:0]     frames_q, frames_d;
  logic [lpr_pkg::FAULT_W-1:0]   fault_q, fault_d;
  logic                          cfg_wr;
  logic                          accept;
  logic [lpr_pkg::NUM_W-1:0]     active_n;
  lpr_pkg::ctrl_t                ctrl;
  lpr_pkg::stat_t                stat [F];
  logic [lpr_pkg::RANK_W-1:0]    rank [F];
  logic [lpr_pkg::PAGE_BITS-1:0] cell_page [F];
  logic [F:0]                    empty_seen;
  logic [F-1:0]                  sel;
  logic                          any_hit;
  logic                          any_empty;
  logic [lpr_pkg::RANK_W-1:0]    hit_rank;
  logic [lpr_pkg::PAGE_BITS-1:0] ev_page;
  logic [lpr_pkg::SLOT_W-1:0]    slot;
  logic [lpr_pkg::PAGE_BITS-1:0] page;
  logic                          evict;

  // Output registers
  logic                              done_q;
  logic                              hit_q;
  logic [lpr_pkg::FRAME_SLOT_W-1:0]  slot_q;
  logic                              ev_valid_q;
  logic [lpr_pkg::PAGE_PORT_W-1:0]   ev_page_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start & ~busy;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == lpr_pkg::REG_FRAMES_IN_USE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == lpr_pkg::REG_FRAMES_IN_USE) begin
      prdata = lpr_pkg::APB_DATA_W'(frames_q);
    end
  end

  assign frames_d = cfg_wr ? pwdata[lpr_pkg::CFG_W-1:0] : frames_q;

  // Zero acts as one frame, anything above the built count as all frames
  always_comb begin
    if (frames_q == '0) begin
      active_n = lpr_pkg::NUM_W'(1);
    end else if (32'(frames_q) > F) begin
      active_n = lpr_pkg::NUM_W'(F);
    end else begin
      active_n = lpr_pkg::NUM_W'(frames_q);
    end
  end

  assign page = lpr_pkg::PAGE_BITS'(page_number_i);

  assign ctrl.clr       = cfg_wr;
  assign ctrl.upd       = accept;
  assign ctrl.hit       = any_hit;
  assign ctrl.hit_rank  = hit_rank;
  assign ctrl.last_rank = lpr_pkg::RANK_W'(active_n - lpr_pkg::NUM_W'(1));
  assign ctrl.active_n  = active_n;

  assign empty_seen[0] = 1'b0;

  for (genvar g = 0; g < F; g++) begin : g_cell
    lpr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .idx_i        (lpr_pkg::SLOT_W'(g)),
      .ctrl_i       (ctrl),
      .page_i       (page),
      .sel_i        (sel[g]),
      .empty_seen_i (empty_seen[g]),
      .empty_seen_o (empty_seen[g+1]),
      .stat_o       (stat[g]),
      .rank_o       (rank[g]),
      .page_o       (cell_page[g])
    );
  end

  assign any_empty = empty_seen[F];

  always_comb begin
    any_hit  = 1'b0;
    hit_rank = '0;
    for (int i = 0; i < F; i++) begin
      any_hit  = any_hit | stat[i].match;
      hit_rank = hit_rank | (stat[i].match ? rank[i] : '0);
    end
  end

  assign evict = ~any_hit & ~any_empty;

  always_comb begin
    sel     = '0;
    slot    = '0;
    ev_page = '0;
    for (int i = 0; i < F; i++) begin
      if (any_hit) begin
        sel[i] = stat[i].match;
      end else if (any_empty) begin
        sel[i] = stat[i].first_empty;
      end else begin
        sel[i] = stat[i].victim;
      end
      slot    = slot | (sel[i] ? lpr_pkg::SLOT_W'(i) : '0);
      ev_page = ev_page | (sel[i] ? cell_page[i] : '0);
    end
  end

  always_comb begin
    fault_d = fault_q;
    if (cfg_wr) begin
      fault_d = '0;
    end else if (accept && !any_hit && (fault_q != '1)) begin
      fault_d = fault_q + lpr_pkg::FAULT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lpr_pkg::FRAMES_IN_USE_RST;
      fault_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      frames_q <= frames_d;
      fault_q  <= fault_d;
      done_q   <= accept & ~cfg_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q      <= any_hit;
      slot_q     <= lpr_pkg::FRAME_SLOT_W'(slot);
      ev_valid_q <= evict;
      ev_page_q  <= evict ? lpr_pkg::PAGE_PORT_W'(ev_page) : '0;
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign frame_slot_o    = slot_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_total_o   = fault_q;

endmodule

### rtl/lpr_cell.sv
// ----------------------------------------------------------------------------
// lpr_cell
// One page frame: page tag, valid bit and recency rank (0 = newest).
// ----------------------------------------------------------------------------
module lpr_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lpr_pkg::SLOT_W-1:0]     idx_i,
  input  lpr_pkg::ctrl_t                 ctrl_i,
  input  logic [lpr_pkg::PAGE_BITS-1:0]  page_i,
  input  logic                           sel_i,
  input  logic                           empty_seen_i,
  output logic                           empty_seen_o,
  output lpr_pkg::stat_t                 stat_o,
  output logic [lpr_pkg::RANK_W-1:0]     rank_o,
  output logic [lpr_pkg::PAGE_BITS-1:0]  page_o
);

  logic                          valid_q, valid_d;
  logic [lpr_pkg::RANK_W-1:0]    rank_q, rank_d;
  logic [lpr_pkg::PAGE_BITS-1:0] page_q, page_d;
  logic                          active;
  logic                          occupied;
  logic                          empty_here;
  logic                          age;

  assign active     = lpr_pkg::NUM_W'(idx_i) < ctrl_i.active_n;
  assign occupied   = active & valid_q;
  assign empty_here = active & ~valid_q;

  // Lowest empty frame wins: the carry tells later cells one was already seen
  assign empty_seen_o       = empty_seen_i | empty_here;
  assign stat_o.match       = occupied & (page_q == page_i);
  assign stat_o.first_empty = empty_here & ~empty_seen_i;
  // Ranks of a full set form a permutation, so the oldest has rank n-1
  assign stat_o.victim      = occupied & (rank_q == ctrl_i.last_rank);

  // On a hit only frames newer than the hit frame age
  assign age = occupied & (~ctrl_i.hit | (rank_q < ctrl_i.hit_rank));

  assign rank_o = rank_q;
  assign page_o = page_q;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    page_d  = page_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
      rank_d  = '0;
    end else if (ctrl_i.upd) begin
      if (sel_i) begin
        rank_d = '0;
        if (!ctrl_i.hit) begin
          valid_d = 1'b1;
          page_d  = page_i;
        end
      end else if (age) begin
        rank_d = rank_q + lpr_pkg::RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

### rtl/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks for the LRU page replacement unit.
// ----------------------------------------------------------------------------
module lpr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             done_o,
  input logic                             hit_o,
  input logic                             evicted_valid_o,
  input logic [lpr_pkg::PAGE_PORT_W-1:0]  evicted_page_o,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite
);

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;

  // Every item accepted outside an APB write gives a result in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !cfg_wr |=> done_o)
    else $error("item accepted without a result");

  // No result without an accepted item
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without an item");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

  // Evicted page reads zero when nothing was replaced
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !evicted_valid_o |-> evicted_page_o == '0)
    else $error("evicted page not zero");

endmodule

bind lru_page_replacement_unit lpr_checker u_lpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .hit_o           (hit_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite)
);
